// ----- sv/issb_pkg.sv -----
package issb_pkg;

    localparam int MAX_SIDE      = 64;
    localparam int PALETTE_DEPTH = 16;

    localparam int COL_W   = $clog2(MAX_SIDE);
    localparam int SIDE_W  = $clog2(MAX_SIDE + 1);
    localparam int LEN_W   = $clog2(MAX_SIDE + 1);
    localparam int IDX_W   = 4;
    localparam int COLOR_W = 16;
    localparam int ORIG_W  = 11;
    localparam int SCALE_W = 4;
    localparam int COORD_W = 16;
    localparam int WIDTH_W = 10;
    localparam int POS_W   = COL_W + SCALE_W;
    localparam int SPAN_W  = LEN_W + SCALE_W;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_SCALE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SIDE_PIXELS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TINT_COLOR  = 3'd4;

    localparam logic OP_PALETTE_WRITE = 1'b0;
    localparam logic OP_PIXEL         = 1'b1;

    localparam logic [SCALE_W-1:0] SCALE_RESET = 4'd1;
    localparam logic [SIDE_W-1:0]  SIDE_RESET  = 7'd16;

endpackage

// ----- sv/indexed_sprite_span_blitter.sv -----
// Channel   Direction  Ports                          Carries
// s_        in         s_tvalid s_tready s_tdata      palette writes and art pixels
//                      s_tuser
// m_        out        m_tvalid m_tready m_tdata      filled-rectangle commands
//                      m_tuser m_tlast
// cfg_      in         cfg_we cfg_index cfg_data      register writes, no handshake
//
// One input transfer per cycle while s_tready is high; a pixel closing two runs
// holds s_tready low until both commands have left through the single output
// register, which sends one command per cycle while m_tready allows. The edge that
// accepts a pixel loads the palette read and the command stage; the output
// register is loaded from the command stage once it is free.
// Reset is synchronous and active low; it clears counters, run state and
// registers, but leaves the palette contents undefined until written.
// A stalled m_tready backs up into the command stage and then into s_tready.
module indexed_sprite_span_blitter (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [3:0] pixel_index, [19:4] entry_color, [23:20] zero
    input  logic [23:0]                         s_tdata,
    // [0] operation
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [15:0] rect_x, [31:16] rect_y, [41:32] rect_width, [45:42] rect_height,
    // [61:46] rect_color, [63:62] zero
    output logic [63:0]                         m_tdata,
    // [0] sprite_done
    output logic                                m_tuser,
    output logic                                m_tlast,
    input  logic                                cfg_we,
    input  logic [issb_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [issb_pkg::CFG_DATA_W-1:0]     cfg_data
);

    logic [issb_pkg::ORIG_W-1:0]  origin_x_reg;
    logic [issb_pkg::ORIG_W-1:0]  origin_y_reg;
    logic [issb_pkg::SCALE_W-1:0] scale_reg;
    logic [issb_pkg::SIDE_W-1:0]  side_reg;
    logic [issb_pkg::COLOR_W-1:0] tint_reg;

    logic [issb_pkg::COL_W-1:0]   col_reg, col_next;
    logic [issb_pkg::COL_W-1:0]   row_reg, row_next;
    logic [issb_pkg::COL_W-1:0]   run_start_reg, run_start_next;
    logic [issb_pkg::LEN_W-1:0]   run_len_reg, run_len_next;
    logic [issb_pkg::IDX_W-1:0]   run_cidx_reg, run_cidx_next;
    logic                         run_open_reg, run_open_next;

    logic [issb_pkg::COLOR_W-1:0] palette_mem [issb_pkg::PALETTE_DEPTH];
    logic [issb_pkg::COLOR_W-1:0] rd0_reg, rd1_reg;

    logic                         a_valid_reg, a_two_reg, a_sel_reg, a_done_reg;
    logic [issb_pkg::POS_W-1:0]   a_px0_reg, a_px1_reg, a_py_reg;
    logic [issb_pkg::SPAN_W-1:0]  a_pw0_reg, a_pw1_reg;

    logic                         m_valid_reg;
    logic [issb_pkg::COORD_W-1:0] m_x_reg, m_y_reg;
    logic [issb_pkg::WIDTH_W-1:0] m_w_reg;
    logic [issb_pkg::SCALE_W-1:0] m_h_reg;
    logic [issb_pkg::COLOR_W-1:0] m_color_reg;
    logic                         m_last_reg, m_done_reg;

    logic [issb_pkg::IDX_W-1:0]   in_idx;
    logic [issb_pkg::COLOR_W-1:0] in_color;
    logic                         in_accept, pix_accept, pal_write;
    logic [issb_pkg::SCALE_W-1:0] scale_eff;
    logic [issb_pkg::SIDE_W-1:0]  side_eff;
    logic                         close_a, close_b, last_col, last_row;
    logic                         open_mid, open_aft;
    logic [issb_pkg::LEN_W-1:0]   len_mid, len_aft;
    logic [issb_pkg::COL_W-1:0]   start_aft;
    logic [issb_pkg::IDX_W-1:0]   cidx_aft, slot0_cidx;
    logic [issb_pkg::COL_W-1:0]   slot0_start;
    logic [issb_pkg::LEN_W-1:0]   slot0_len;
    logic                         a_load, out_load, a_finish;
    logic [issb_pkg::POS_W-1:0]   sel_px;
    logic [issb_pkg::SPAN_W-1:0]  sel_pw;
    logic [issb_pkg::COLOR_W-1:0] sel_rd;

    assign in_idx     = s_tdata[issb_pkg::IDX_W-1:0];
    assign in_color   = s_tdata[issb_pkg::IDX_W+issb_pkg::COLOR_W-1:issb_pkg::IDX_W];
    assign in_accept  = s_tvalid && s_tready;
    assign pix_accept = in_accept && (s_tuser == issb_pkg::OP_PIXEL);
    assign pal_write  = in_accept && (s_tuser == issb_pkg::OP_PALETTE_WRITE);

    assign scale_eff = (scale_reg == '0) ? issb_pkg::SCALE_W'(1) : scale_reg;

    always_comb begin
        if (side_reg == '0) begin
            side_eff = issb_pkg::SIDE_W'(1);
        end else if (side_reg > issb_pkg::SIDE_W'(issb_pkg::MAX_SIDE)) begin
            side_eff = issb_pkg::SIDE_W'(issb_pkg::MAX_SIDE);
        end else begin
            side_eff = side_reg;
        end
    end

    // Run tracking for the accepted pixel: close the old run on a color change,
    // extend or open a run, then close whatever is open at the end of the row.
    always_comb begin
        close_a   = run_open_reg && (in_idx != run_cidx_reg);
        open_mid  = close_a ? 1'b0 : run_open_reg;
        len_mid   = close_a ? '0 : run_len_reg;
        open_aft  = open_mid;
        len_aft   = len_mid;
        start_aft = run_start_reg;
        cidx_aft  = run_cidx_reg;
        if (in_idx != '0) begin
            if (!open_mid) begin
                open_aft  = 1'b1;
                start_aft = col_reg;
                len_aft   = issb_pkg::LEN_W'(1);
                cidx_aft  = in_idx;
            end else begin
                len_aft = len_mid + issb_pkg::LEN_W'(1);
            end
        end

        last_col = ({1'b0, col_reg} + issb_pkg::SIDE_W'(1)) >= side_eff;
        last_row = ({1'b0, row_reg} + issb_pkg::SIDE_W'(1)) >= side_eff;
        close_b  = last_col && open_aft;

        run_open_next  = close_b ? 1'b0 : open_aft;
        run_len_next   = close_b ? '0 : len_aft;
        run_start_next = start_aft;
        run_cidx_next  = cidx_aft;
        col_next       = last_col ? '0 : col_reg + issb_pkg::COL_W'(1);
        row_next       = last_col ? (last_row ? '0 : row_reg + issb_pkg::COL_W'(1)) : row_reg;

        slot0_start = close_a ? run_start_reg : start_aft;
        slot0_len   = close_a ? run_len_reg : len_aft;
        slot0_cidx  = close_a ? run_cidx_reg : cidx_aft;
    end

    assign out_load = a_valid_reg && (!m_valid_reg || m_tready);
    assign a_finish = out_load && (!a_two_reg || a_sel_reg);
    assign s_tready = !a_valid_reg || a_finish;
    assign a_load   = pix_accept && (close_a || close_b);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            origin_x_reg <= '0;
            origin_y_reg <= '0;
            scale_reg    <= issb_pkg::SCALE_RESET;
            side_reg     <= issb_pkg::SIDE_RESET;
            tint_reg     <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                issb_pkg::CFG_ORIGIN_X:    origin_x_reg <= cfg_data[issb_pkg::ORIG_W-1:0];
                issb_pkg::CFG_ORIGIN_Y:    origin_y_reg <= cfg_data[issb_pkg::ORIG_W-1:0];
                issb_pkg::CFG_PIXEL_SCALE: scale_reg    <= cfg_data[issb_pkg::SCALE_W-1:0];
                issb_pkg::CFG_SIDE_PIXELS: side_reg     <= cfg_data[issb_pkg::SIDE_W-1:0];
                issb_pkg::CFG_TINT_COLOR:  tint_reg     <= cfg_data[issb_pkg::COLOR_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg       <= '0;
            row_reg       <= '0;
            run_start_reg <= '0;
            run_len_reg   <= '0;
            run_cidx_reg  <= '0;
            run_open_reg  <= 1'b0;
        end else if (pix_accept) begin
            col_reg       <= col_next;
            row_reg       <= row_next;
            run_start_reg <= run_start_next;
            run_len_reg   <= run_len_next;
            run_cidx_reg  <= run_cidx_next;
            run_open_reg  <= run_open_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pal_write) begin
            palette_mem[in_idx] <= in_color;
        end
        if (a_load) begin
            rd0_reg <= palette_mem[slot0_cidx];
            rd1_reg <= palette_mem[cidx_aft];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            a_two_reg   <= 1'b0;
            a_sel_reg   <= 1'b0;
        end else if (a_load) begin
            a_valid_reg <= 1'b1;
            a_two_reg   <= close_a && close_b;
            a_sel_reg   <= 1'b0;
        end else if (a_finish) begin
            a_valid_reg <= 1'b0;
            a_two_reg   <= 1'b0;
            a_sel_reg   <= 1'b0;
        end else if (out_load) begin
            a_sel_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_load) begin
            a_done_reg <= last_col && last_row;
            a_px0_reg  <= issb_pkg::POS_W'(slot0_start) * issb_pkg::POS_W'(scale_eff);
            a_px1_reg  <= issb_pkg::POS_W'(start_aft) * issb_pkg::POS_W'(scale_eff);
            a_pw0_reg  <= issb_pkg::SPAN_W'(slot0_len) * issb_pkg::SPAN_W'(scale_eff);
            a_pw1_reg  <= issb_pkg::SPAN_W'(len_aft) * issb_pkg::SPAN_W'(scale_eff);
            a_py_reg   <= issb_pkg::POS_W'(row_reg) * issb_pkg::POS_W'(scale_eff);
        end
    end

    assign sel_px = a_sel_reg ? a_px1_reg : a_px0_reg;
    assign sel_pw = a_sel_reg ? a_pw1_reg : a_pw0_reg;
    assign sel_rd = a_sel_reg ? rd1_reg : rd0_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_x_reg <= {{(issb_pkg::COORD_W-issb_pkg::ORIG_W){origin_x_reg[issb_pkg::ORIG_W-1]}},
                        origin_x_reg} + issb_pkg::COORD_W'(sel_px);
            m_y_reg <= {{(issb_pkg::COORD_W-issb_pkg::ORIG_W){origin_y_reg[issb_pkg::ORIG_W-1]}},
                        origin_y_reg} + issb_pkg::COORD_W'(a_py_reg);
            m_w_reg <= (sel_pw > issb_pkg::SPAN_W'({issb_pkg::WIDTH_W{1'b1}}))
                       ? {issb_pkg::WIDTH_W{1'b1}} : sel_pw[issb_pkg::WIDTH_W-1:0];
            m_h_reg     <= scale_eff;
            m_color_reg <= (tint_reg != '0) ? tint_reg : sel_rd;
            m_last_reg  <= a_sel_reg || !a_two_reg;
            m_done_reg  <= a_done_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, m_color_reg, m_h_reg, m_w_reg, m_y_reg, m_x_reg};
    assign m_tuser  = m_done_reg;
    assign m_tlast  = m_last_reg;

`ifndef SYNTH
    a_sel_needs_two: assert property (@(posedge aclk) disable iff (!aresetn)
        a_sel_reg |-> (a_two_reg && a_valid_reg))
        else $error("Second command selected without a pending pair.");

    a_holds_unsent: assert property (@(posedge aclk) disable iff (!aresetn)
        (a_valid_reg && !out_load) |=> (a_valid_reg && $stable(a_sel_reg)))
        else $error("Pending command dropped before it was sent.");

    run_open_len: assert property (@(posedge aclk) disable iff (!aresetn)
        run_open_reg |-> ((run_len_reg != '0) && (run_cidx_reg != '0)))
        else $error("Open run has zero length or transparent color.");

    run_closed_len: assert property (@(posedge aclk) disable iff (!aresetn)
        !run_open_reg |-> (run_len_reg == '0))
        else $error("Closed run keeps a length.");
`endif

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_ITEMS = 1600;

    typedef struct packed {
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic [9:0]  span;
        logic [3:0]  height;
        logic [15:0] color;
        logic        last_cmd;
        logic        sprite_end;
    } rect_cmd_t;

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        cfg_we = 1'b0;
    logic [issb_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [issb_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    indexed_sprite_span_blitter uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Shadow of the block's registers and sprite walk state.
    logic signed [10:0] org_x = '0;
    logic signed [10:0] org_y = '0;
    logic [3:0]         scale_reg = 4'd1;
    logic [6:0]         side_reg = 7'd16;
    logic [15:0]        tint_reg = '0;
    logic [15:0]        pal_mem [issb_pkg::PALETTE_DEPTH];
    logic [5:0]         col_cnt = '0;
    logic [5:0]         row_cnt = '0;
    logic [5:0]         run_col0 = '0;
    logic [6:0]         run_len = '0;
    logic [3:0]         run_idx = '0;
    logic               run_active = 1'b0;

    rect_cmd_t expected_rects [$];

    logic steady = 1'b0;
    int   cycle_count = 0;
    int   mismatch_count = 0;
    int   items_sent = 0;
    int   pixels_sent = 0;
    int   writes_sent = 0;
    int   rects_checked = 0;
    int   sprites_done = 0;
    int   settings_count = 0;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles.", cycle_count);
            $display("FAILURE");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_tready <= steady || ($urandom_range(99) >= 34);
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("Mismatch on %s at cycle %0d: got %0h, expected %0h.",
                 what, cycle_count, got, want);
        mismatch_count++;
    endtask

    always @(posedge aclk) begin : rect_check
        rect_cmd_t got;
        rect_cmd_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.pos_x      = m_tdata[15:0];
            got.pos_y      = m_tdata[31:16];
            got.span       = m_tdata[41:32];
            got.height     = m_tdata[45:42];
            got.color      = m_tdata[61:46];
            got.last_cmd   = m_tlast;
            got.sprite_end = m_tuser;
            if (expected_rects.size() == 0) begin
                report_mismatch("unexpected command", m_tdata[31:0], '0);
            end else begin
                want = expected_rects.pop_front();
                rects_checked++;
                if (got.pos_x !== want.pos_x) report_mismatch("rect_x", got.pos_x, want.pos_x);
                if (got.pos_y !== want.pos_y) report_mismatch("rect_y", got.pos_y, want.pos_y);
                if (got.span !== want.span) report_mismatch("rect_width", got.span, want.span);
                if (got.height !== want.height)
                    report_mismatch("rect_height", got.height, want.height);
                if (got.color !== want.color) report_mismatch("rect_color", got.color, want.color);
                if (got.last_cmd !== want.last_cmd)
                    report_mismatch("last_of_item", got.last_cmd, want.last_cmd);
                if (got.sprite_end !== want.sprite_end)
                    report_mismatch("sprite_done", got.sprite_end, want.sprite_end);
            end
        end
    end

    function automatic rect_cmd_t close_run();
        rect_cmd_t r;
        int s;
        int xi;
        int yi;
        int wi;
        s  = (scale_reg == 0) ? 1 : int'(scale_reg);
        xi = int'(org_x) + int'(run_col0) * s;
        yi = int'(org_y) + int'(row_cnt) * s;
        wi = int'(run_len) * s;
        if (wi > 1023) wi = 1023;
        r.pos_x      = xi[15:0];
        r.pos_y      = yi[15:0];
        r.span       = wi[9:0];
        r.height     = s[3:0];
        r.color      = (tint_reg != 0) ? tint_reg : pal_mem[run_idx];
        r.last_cmd   = 1'b0;
        r.sprite_end = 1'b0;
        run_active = 1'b0;
        run_len    = '0;
        return r;
    endfunction

    function automatic void predict_pixel(input logic [3:0] idx);
        rect_cmd_t cmds [2];
        int n;
        int eside;
        logic done;
        n = 0;
        done = 1'b0;
        eside = (side_reg == 0) ? 1 : ((side_reg > issb_pkg::MAX_SIDE) ? issb_pkg::MAX_SIDE
                                                                       : int'(side_reg));
        if (run_active && idx != run_idx) begin
            cmds[n] = close_run();
            n++;
        end
        if (idx != 0) begin
            if (!run_active) begin
                run_active = 1'b1;
                run_col0   = col_cnt;
                run_len    = 7'd1;
                run_idx    = idx;
            end else begin
                run_len++;
            end
        end
        if (int'(col_cnt) + 1 >= eside) begin
            if (run_active) begin
                cmds[n] = close_run();
                n++;
            end
            col_cnt = '0;
            if (int'(row_cnt) + 1 >= eside) begin
                row_cnt = '0;
                done = 1'b1;
                sprites_done++;
            end else begin
                row_cnt++;
            end
        end else begin
            col_cnt++;
        end
        for (int k = 0; k < n; k++) begin
            cmds[k].sprite_end = done;
            cmds[k].last_cmd   = (k == n - 1);
            expected_rects.push_back(cmds[k]);
        end
    endfunction

    // Valid stays high after a transfer; it only drops when a gap is taken
    // or when the sender goes quiet.
    task automatic send_item(input logic op, input logic [3:0] idx, input logic [15:0] color);
        if (!steady) begin
            while ($urandom_range(99) < 34) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {4'b0000, color, idx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
        if (op == issb_pkg::OP_PIXEL) begin
            pixels_sent++;
            predict_pixel(idx);
        end else begin
            writes_sent++;
            pal_mem[idx] = color;
        end
    endtask

    task automatic drain_commands();
        s_tvalid <= 1'b0;
        while (expected_rects.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [issb_pkg::CFG_IDX_W-1:0] index,
                             input logic [15:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge aclk);
    endtask

    task automatic apply_settings(input logic signed [10:0] ox, input logic signed [10:0] oy,
                                  input logic [3:0] sc, input logic [6:0] sd,
                                  input logic [15:0] tn);
        cfg_write(issb_pkg::CFG_ORIGIN_X, {{5{ox[10]}}, ox});
        cfg_write(issb_pkg::CFG_ORIGIN_Y, {{5{oy[10]}}, oy});
        cfg_write(issb_pkg::CFG_PIXEL_SCALE, {12'b0, sc});
        cfg_write(issb_pkg::CFG_SIDE_PIXELS, {9'b0, sd});
        cfg_write(issb_pkg::CFG_TINT_COLOR, tn);
        cfg_we <= 1'b0;
        org_x     = ox;
        org_y     = oy;
        scale_reg = sc;
        side_reg  = sd;
        tint_reg  = tn;
        settings_count++;
    endtask

    function automatic logic [10:0] pick_origin();
        case ($urandom_range(5))
            0: begin
                return 11'h400;
            end
            1: begin
                return 11'h3FF;
            end
            default: begin
                return 11'($urandom_range(2047));
            end
        endcase
    endfunction

    task automatic test_palette_load();
        int e;
        for (e = 0; e < issb_pkg::PALETTE_DEPTH; e++) begin
            if (e == 1) begin
                send_item(issb_pkg::OP_PALETTE_WRITE, e[3:0], 16'hFFFF);
            end else if (e == 2) begin
                send_item(issb_pkg::OP_PALETTE_WRITE, e[3:0], 16'h0000);
            end else begin
                send_item(issb_pkg::OP_PALETTE_WRITE, e[3:0], 16'($urandom_range(65535)));
            end
        end
        drain_commands();
    endtask

    // Two-pixel-wide sprites: merged runs, a pixel closing two runs,
    // a run closed by a transparent pixel, and a sprite that ends silently.
    task automatic test_run_merging();
        logic [3:0] art [12] = '{4'd3, 4'd3, 4'd5, 4'd7, 4'd0, 4'd0, 4'd15, 4'd0,
                                 4'd4, 4'd0, 4'd0, 4'd0};
        apply_settings(11'sd0, 11'sd0, 4'd1, 7'd2, 16'h0000);
        foreach (art[i]) send_item(issb_pkg::OP_PIXEL, art[i], 16'($urandom_range(65535)));
        drain_commands();
    endtask

    task automatic test_extremes();
        apply_settings(11'h400, 11'h3FF, 4'd0, 7'd0, 16'hFFFF);
        send_item(issb_pkg::OP_PIXEL, 4'd9, 16'hFFFF);
        send_item(issb_pkg::OP_PIXEL, 4'd0, 16'h0000);
        send_item(issb_pkg::OP_PIXEL, 4'd12, 16'h0000);
        drain_commands();
    endtask

    task automatic test_side_shrink();
        apply_settings(11'h3FF, 11'h400, 4'd15, 7'd127, 16'h0000);
        send_item(issb_pkg::OP_PIXEL, 4'd2, 16'h0000);
        send_item(issb_pkg::OP_PIXEL, 4'd2, 16'h0000);
        send_item(issb_pkg::OP_PIXEL, 4'd0, 16'h0000);
        send_item(issb_pkg::OP_PIXEL, 4'd6, 16'h0000);
        send_item(issb_pkg::OP_PIXEL, 4'd6, 16'h0000);
        drain_commands();
        apply_settings(11'h3FF, 11'h400, 4'd15, 7'd3, 16'h0000);
        send_item(issb_pkg::OP_PIXEL, 4'd6, 16'h0000);
        send_item(issb_pkg::OP_PIXEL, 4'd1, 16'h0000);
        drain_commands();
    endtask

    task automatic test_random_stream();
        int start;
        int phase;
        int n;
        int j;
        int r;
        int len;
        logic [3:0] sc;
        logic [6:0] sd;
        logic [15:0] tn;
        logic [3:0] idx;
        start = items_sent;
        phase = 0;
        while (items_sent < start + RANDOM_ITEMS) begin
            drain_commands();
            r = $urandom_range(9);
            sc = (r == 0) ? 4'($urandom_range(15)) : (r == 1) ? 4'd8 : (r == 2) ? 4'd1
                                                   : 4'($urandom_range(1, 8));
            r = $urandom_range(11);
            sd = (r == 0) ? 7'd0 : (r == 1) ? 7'd64 : (r == 2) ? 7'd127
               : (r == 3) ? 7'($urandom_range(9, 127)) : 7'($urandom_range(1, 8));
            r = $urandom_range(5);
            tn = (r < 3) ? 16'h0000 : (r == 3) ? 16'hFFFF : 16'($urandom_range(65535));
            apply_settings(pick_origin(), pick_origin(), sc, sd, tn);
            steady = (phase == 2);
            n = steady ? 250 : $urandom_range(40, 160);
            j = 0;
            while (j < n) begin
                r = $urandom_range(99);
                if (r < 8) begin
                    send_item(issb_pkg::OP_PALETTE_WRITE, 4'($urandom_range(15)),
                              16'($urandom_range(65535)));
                    j++;
                end else if (r < 14) begin
                    send_item(issb_pkg::OP_PIXEL, 4'($urandom_range(15)),
                              16'($urandom_range(65535)));
                    j++;
                end else begin
                    idx = ($urandom_range(3) == 0) ? 4'd0 : 4'($urandom_range(1, 15));
                    len = ($urandom_range(9) == 0) ? $urandom_range(1, 64)
                                                   : $urandom_range(1, 6);
                    repeat (len) send_item(issb_pkg::OP_PIXEL, idx, 16'($urandom_range(65535)));
                    j += len;
                end
            end
            phase++;
        end
        steady = 1'b0;
        drain_commands();
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_palette_load();
        test_run_merging();
        test_extremes();
        test_side_shrink();
        test_random_stream();
        repeat (6) @(posedge aclk);
        if (expected_rects.size() != 0)
            report_mismatch("commands never delivered", expected_rects.size(), '0);
        $display("Sent %0d items (%0d pixels, %0d palette writes) under %0d register settings.",
                 items_sent, pixels_sent, writes_sent, settings_count);
        $display("Checked %0d rectangle commands; %0d sprites completed; %0d mismatches.",
                 rects_checked, sprites_done, mismatch_count);
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
